[src/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache
// Sizes, the operation and state codes, and the row and request structs
// that pass between the sequencer, the compare unit and the entry store.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  // One stored entry, kept as one memory row.
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] stamp;
  } lfu_row_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    lfu_row_t         row;
  } wr_req_t;

  // Best replacement candidate seen so far in a scan.
  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] age;
  } best_t;

  typedef struct packed {
    logic              match;
    logic              better;
    logic [DATA_W-1:0] age;
  } rank_t;

endpackage

[src/lfu_if.sv]
// ----------------------------------------------------------------------------
// lfu_if: request and result channels of the LFU cache
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lfu_in_if;
  import lfu_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [DATA_W-1:0] lookup_key;
  logic [DATA_W-1:0] store_value;

  modport source (output valid, output operation, output lookup_key,
                  output store_value, input ready);
  modport sink   (input valid, input operation, input lookup_key,
                  input store_value, output ready);
endinterface

interface lfu_out_if;
  import lfu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

[src/lfu_rank.sv]
// ----------------------------------------------------------------------------
// lfu_rank: shared key and replacement compare unit
// Checks one entry per cycle for a key match and for being a better
// replacement candidate than the best one found so far.
// ----------------------------------------------------------------------------
module lfu_rank (
  input  lfu_pkg::lfu_row_t           row,
  input  logic [lfu_pkg::DATA_W-1:0]  key,
  input  logic [lfu_pkg::DATA_W-1:0]  now,
  input  lfu_pkg::best_t              best,
  output lfu_pkg::rank_t              rank
);
  import lfu_pkg::*;

  logic [DATA_W-1:0] age;

  // Age wraps modulo the clock width; a larger age is an older entry.
  assign age = now - row.stamp;

  always_comb begin
    rank.match  = (row.key == key);
    rank.age    = age;
    rank.better = !best.found || (row.count < best.count) ||
                  ((row.count == best.count) && (age > best.age));
  end

endmodule

[src/lfu_store.sv]
// ----------------------------------------------------------------------------
// lfu_store: entry memory of the LFU cache
// One row per slot holding key, value, use count and stamp. One write port
// and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfu_store (
  input  logic               clk,
  input  lfu_pkg::rd_req_t   rd,
  input  lfu_pkg::wr_req_t   wr,
  output lfu_pkg::lfu_row_t  rd_row
);
  import lfu_pkg::*;

  lfu_row_t mem [ENTRIES];
  lfu_row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_row_r <= mem[rd.addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

[src/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// lfu_ctrl: sequencer of the LFU cache
// Scans the entry store one slot per cycle through the shared compare unit,
// then performs the update and loads the result register.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lfu_pkg::CNT_W-1:0]   cap,
  lfu_in_if.sink                      in_ch,
  lfu_out_if.source                   out_ch,
  output lfu_pkg::rd_req_t            rd,
  output lfu_pkg::wr_req_t            wr,
  input  lfu_pkg::lfu_row_t           rd_row
);
  import lfu_pkg::*;

  state_t            state_r, state_nxt;

  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   occ_r;
  logic [DATA_W-1:0]  clock_r;

  logic               op_r;
  logic [DATA_W-1:0]  key_r;
  logic [DATA_W-1:0]  val_r;
  logic [CNT_W-1:0]   cap_r;

  logic [CNT_W-1:0]   cnt_r;
  logic               pval_r;
  logic [IDX_W-1:0]   pidx_r;

  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [DATA_W-1:0]  hit_val_r;
  logic [DATA_W-1:0]  hit_cnt_r;

  best_t              best_r;
  logic [IDX_W-1:0]   best_idx_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [DATA_W-1:0]  out_value_r;

  rank_t              rank;
  logic               accept;
  logic               process;
  logic               scan_done;
  logic               stall;
  logic               finish;
  logic [IDX_W-1:0]   free_idx;
  logic [DATA_W-1:0]  hit_cnt_inc;
  logic               set_valid;

  lfu_rank u_rank (
    .row  (rd_row),
    .key  (key_r),
    .now  (clock_r),
    .best (best_r),
    .rank (rank)
  );

  assign accept    = in_ch.valid && in_ch.ready;
  assign process   = (state_r == ST_SCAN) && pval_r && valid_r[pidx_r];
  assign scan_done = (cnt_r == CNT_W'(ENTRIES));
  assign stall     = out_valid_r && !out_ch.ready;
  assign finish    = (state_r == ST_WRITE) && !stall;
  assign hit_cnt_inc = (&hit_cnt_r) ? hit_cnt_r : hit_cnt_r + DATA_W'(1);

  // Lowest slot that holds no entry.
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    rd.en       = 1'b0;
    rd.addr     = cnt_r[IDX_W-1:0];
    wr.we       = 1'b0;
    wr.addr     = hit_idx_r;
    wr.row.key   = key_r;
    wr.row.value = val_r;
    wr.row.count = DATA_W'(1);
    wr.row.stamp = clock_r;
    set_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd.en = !scan_done;
        if (scan_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!stall) begin
          state_nxt = ST_IDLE;
          if (op_r == OP_GET) begin
            if (hit_r) begin
              wr.we        = 1'b1;
              wr.row.value = hit_val_r;
              wr.row.count = hit_cnt_inc;
            end
          end else if (cap_r != '0) begin
            if (hit_r) begin
              wr.we        = 1'b1;
              wr.row.count = hit_cnt_inc;
            end else if (occ_r < cap_r) begin
              wr.we     = 1'b1;
              wr.addr   = free_idx;
              set_valid = 1'b1;
            end else if (best_r.found) begin
              wr.we   = 1'b1;
              wr.addr = best_idx_r;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Store bookkeeping: valid bits, occupancy and the access clock.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      clock_r <= '0;
    end else begin
      if (wr.we) begin
        clock_r <= clock_r + DATA_W'(1);
      end
      if (set_valid) begin
        valid_r[free_idx] <= 1'b1;
        occ_r             <= occ_r + CNT_W'(1);
      end
    end
  end

  // Item capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r          <= in_ch.operation;
      key_r         <= in_ch.lookup_key;
      val_r         <= in_ch.store_value;
      cap_r         <= cap;
      cnt_r         <= '0;
      pval_r        <= 1'b0;
      hit_r         <= 1'b0;
      best_r.found  <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      pval_r <= !scan_done;
      pidx_r <= cnt_r[IDX_W-1:0];
      if (!scan_done) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (process && rank.match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= pidx_r;
        hit_val_r <= rd_row.value;
        hit_cnt_r <= rd_row.count;
      end
      if (process && rank.better) begin
        best_r.found <= 1'b1;
        best_r.count <= rd_row.count;
        best_r.age   <= rank.age;
        best_idx_r   <= pidx_r;
      end
    end
  end

  // Result register; a finished word waits here for the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_found_r <= hit_r;
      out_value_r <= ((op_r == OP_GET) && hit_r) ? hit_val_r : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.read_value = out_value_r;

  // Occupancy always equals the number of valid slots.
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == CNT_W'($countones(valid_r)))
    else $error("occupancy differs from number of valid slots");

  // Valid bits change only when an update is committed.
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !finish |=> $stable(valid_r))
    else $error("valid bits changed outside of an update");

  // The access clock advances only together with a row write.
  a_clock_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr.we |=> $stable(clock_r))
    else $error("access clock moved without a row write");

  // A result appears only after the update state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_WRITE)
    else $error("result raised outside of the update state");

endmodule

[src/lfu_cache_lru_tiebreak_top.sv]
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_top: LFU key-value cache with LRU tie break
// Sixteen-entry store with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_ch as a word of operation (0 get, 1 put), key and
// value; results leave on out_ch as a word of found flag and read value, one
// result per request, in order. Both channels move a word when valid and
// ready are both high.
// Each request passes through these steps from acceptance to the result
// register: capture, a scan of the sixteen slots of the entry memory one slot
// per cycle through the shared compare unit, the last read data, and the
// commit of the update. The single read port of the entry memory sets the
// pace of the scan. in_ch is ready only while the sequencer is idle, so a new
// request can be taken in the cycle after the commit, and not before.
// A result waiting in the output register does not block the next request;
// a commit waits only while an earlier result is still not taken.
// Reset (rst_n low, synchronous) clears all valid bits, occupancy and the
// access clock and sets capacity to sixteen; no clearing pass is needed.
// cfg_we writes capacity from cfg_wdata; write it only while idle.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
  lfu_in_if.sink                    in_ch,
  lfu_out_if.source                 out_ch
);
  import lfu_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] cap_eff;
  rd_req_t          rd;
  wr_req_t          wr;
  lfu_row_t         rd_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // A capacity above the number of slots acts as a full store.
  assign cap_eff = (cap_r > CAP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cap_r);

  lfu_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cap    (cap_eff),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .rd     (rd),
    .wr     (wr),
    .rd_row (rd_row)
  );

  lfu_store u_store (
    .clk    (clk),
    .rd     (rd),
    .wr     (wr),
    .rd_row (rd_row)
  );

endmodule
